[sv/b2bcd_pkg.sv]
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared widths, constants and types of the binary to BCD digit scan.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = 4;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0]   CNT_RESET = CNT_W'(3);
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_DIGITS);
    // ceil(2^35 / 10): quotient by ten is (value * RECIP_10) >> RECIP_SHIFT
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   cnt;
        logic [POS_W-1:0]   pos;
    } t_cell_fwd;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
        logic [POS_W-1:0]   position;
        logic               last;
        logic               error;
    } t_cell_res;

endpackage

[sv/b2bcd_in_if.sv]
// ----------------------------------------------------------------------------
// b2bcd_in_if
// Request channel carrying one binary value.
// ----------------------------------------------------------------------------
interface b2bcd_in_if;
    import b2bcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[sv/b2bcd_out_if.sv]
// ----------------------------------------------------------------------------
// b2bcd_out_if
// Result channel carrying one BCD digit with its position and flags.
// ----------------------------------------------------------------------------
interface b2bcd_out_if;
    import b2bcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic               last;
    logic               error;

    modport source (output valid, output digit, output position, output last,
                    output error, input ready);
    modport sink   (input valid, input digit, input position, input last,
                    input error, output ready);
endinterface

[sv/b2bcd_cell.sv]
// ----------------------------------------------------------------------------
// b2bcd_cell
// One digit cell: peels the low decimal digit off the held value and hands
// the quotient by ten to the next cell.
// ----------------------------------------------------------------------------
module b2bcd_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  b2bcd_pkg::t_cell_fwd i_fwd,
    output b2bcd_pkg::t_cell_fwd o_fwd,
    output b2bcd_pkg::t_cell_res o_res
);
    import b2bcd_pkg::*;

    logic                   r_valid;
    logic [VALUE_W-1:0]     r_value;
    logic [CNT_W-1:0]       r_cnt;
    logic [POS_W-1:0]       r_pos;

    logic [2*VALUE_W-1:0]   prod;
    logic [VALUE_W-1:0]     quot;
    logic [DIGIT_W-1:0]     rem;
    logic [POS_W-1:0]       pos_next;
    logic                   err;
    logic                   last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_fwd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= i_fwd.value;
            r_cnt   <= i_fwd.cnt;
            r_pos   <= i_fwd.pos;
        end
    end

    always_comb begin
        prod     = {{VALUE_W{1'b0}}, r_value} * {{VALUE_W{1'b0}}, RECIP_10};
        quot     = VALUE_W'(prod >> RECIP_SHIFT);
        // value - 10*quot, kept to the digit width
        rem      = r_value[DIGIT_W-1:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
        pos_next = r_pos + POS_W'(1);
        err      = (r_cnt == '0) || (r_cnt > CNT_MAX);
        last     = err || (pos_next == r_cnt);
    end

    always_comb begin
        o_res.valid    = r_valid;
        o_res.digit    = err ? '0 : rem;
        o_res.position = err ? '0 : r_pos;
        o_res.last     = last;
        o_res.error    = err;

        o_fwd.valid    = r_valid && !last;
        o_fwd.value    = quot;
        o_fwd.cnt      = r_cnt;
        o_fwd.pos      = pos_next;
    end

endmodule

[sv/binary_to_bcd_digit_scan.sv]
// ----------------------------------------------------------------------------
// binary_to_bcd_digit_scan
// Splits a 32-bit value into BCD digits, least significant first, through a
// row of divide-by-ten cells, one digit result per cycle while o_out is not stalled.
//
//   channel   dir   payload                          handshake
//   i_in      in    value[31:0]                      valid / ready
//   o_out     out   digit, position, last, error     valid / ready
//   cfg       in    i_cfg_wdata[3:0] (digit count)   i_cfg_we
//
// A request passes through digit_count cells (1..10), one digit per cell; an
// out-of-range count gives a single error result. The next request enters
// cell 0 in the cycle the last digit of the current one leaves.
// Reset clears the cells and output register and sets digit_count to 3.
// A stall on o_out freezes the whole row; the output register holds.
// ----------------------------------------------------------------------------
module binary_to_bcd_digit_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [b2bcd_pkg::CNT_W-1:0] i_cfg_wdata,
    b2bcd_in_if.sink                    i_in,
    b2bcd_out_if.source                 o_out
);
    import b2bcd_pkg::*;

    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [DIGIT_W-1:0] r_digit;
    logic [POS_W-1:0]   r_position;
    logic               r_last;
    logic               r_error;

    t_cell_fwd          fwd [MAX_DIGITS+1];
    t_cell_res          res [MAX_DIGITS];

    logic               adv;
    logic               in_accept;
    logic               any_valid;
    logic               any_last;
    logic [DIGIT_W-1:0] sel_digit;
    logic [POS_W-1:0]   sel_position;
    logic               sel_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_RESET;
        end else if (i_cfg_we) begin
            r_cnt <= i_cfg_wdata;
        end
    end

    assign adv       = !r_out_valid || o_out.ready;
    assign i_in.ready = adv && (!any_valid || any_last);
    assign in_accept = i_in.valid && i_in.ready;

    always_comb begin
        fwd[0].valid = in_accept;
        fwd[0].value = i_in.value;
        fwd[0].cnt   = r_cnt;
        fwd[0].pos   = '0;
    end

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        b2bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_fwd   (fwd[g]),
            .o_fwd   (fwd[g+1]),
            .o_res   (res[g])
        );
    end

    // at most one cell holds a request at a time
    always_comb begin
        any_valid    = 1'b0;
        any_last     = 1'b0;
        sel_digit    = '0;
        sel_position = '0;
        sel_error    = 1'b0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (res[k].valid) begin
                any_valid    = 1'b1;
                any_last     = any_last | res[k].last;
                sel_digit    = sel_digit | res[k].digit;
                sel_position = sel_position | res[k].position;
                sel_error    = sel_error | res[k].error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= any_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_digit    <= sel_digit;
            r_position <= sel_position;
            r_last     <= any_last;
            r_error    <= sel_error;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.digit    = r_digit;
    assign o_out.position = r_position;
    assign o_out.last     = r_last;
    assign o_out.error    = r_error;

endmodule
